/* hdl/alps_pkg.sv */
// shared types, constants and the micro-program for the admm local primal solve block
// no dependencies
package alps_pkg;

    localparam int RF_AW = 5;
    localparam int PC_W  = 7;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_LT,
        OP_CHKZ,
        OP_CLR,
        OP_LATCH,
        OP_SEL,
        OP_CALL,
        OP_RET,
        OP_END
    } t_op;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_LOAD,
        SQ_FETCH,
        SQ_ISSUE,
        SQ_WAIT,
        SQ_DONE
    } t_seq_state;

    typedef enum logic [1:0] {
        AR_IDLE,
        AR_MUL,
        AR_DIV,
        AR_FIN
    } t_arith_state;

    typedef struct packed {
        logic             start;
        t_op              op;
        logic [31:0]      a;
        logic [31:0]      b;
    } t_arith_req;

    typedef struct packed {
        logic             done;
        logic             flag;
        logic [31:0]      result;
    } t_arith_rsp;

    typedef struct packed {
        t_op              op;
        logic [RF_AW-1:0] d;
        logic [RF_AW-1:0] a;
        logic [RF_AW-1:0] b;
    } t_uop;

    // configuration register indexes
    localparam logic [2:0] CFG_RHO   = 3'd0;
    localparam logic [2:0] CFG_COST  = 3'd1;
    localparam logic [2:0] CFG_EXT   = 3'd2;
    localparam logic [2:0] CFG_LOWER = 3'd3;
    localparam logic [2:0] CFG_OWN   = 3'd4;
    localparam logic [2:0] CFG_GAIN0 = 3'd5;
    localparam logic [2:0] CFG_GAIN1 = 3'd6;

    // register file slots, vectors held in own / other order
    localparam logic [RF_AW-1:0] S_RHO  = 5'd0;
    localparam logic [RF_AW-1:0] S_RH   = 5'd1;
    localparam logic [RF_AW-1:0] S_C    = 5'd2;
    localparam logic [RF_AW-1:0] S_O    = 5'd3;
    localparam logic [RF_AW-1:0] S_L    = 5'd4;
    localparam logic [RF_AW-1:0] S_KO   = 5'd5;
    localparam logic [RF_AW-1:0] S_KT   = 5'd6;
    localparam logic [RF_AW-1:0] S_AO   = 5'd7;
    localparam logic [RF_AW-1:0] S_AT   = 5'd8;
    localparam logic [RF_AW-1:0] S_YO   = 5'd9;
    localparam logic [RF_AW-1:0] S_YT   = 5'd10;
    localparam logic [RF_AW-1:0] S_HUN  = 5'd11;
    localparam logic [RF_AW-1:0] S_NTOL = 5'd12;
    localparam logic [RF_AW-1:0] S_TOL  = 5'd13;
    localparam logic [RF_AW-1:0] S_ZERO = 5'd14;
    localparam logic [RF_AW-1:0] S_ZO   = 5'd15;
    localparam logic [RF_AW-1:0] S_ZT   = 5'd16;
    localparam logic [RF_AW-1:0] S_N    = 5'd17;
    localparam logic [RF_AW-1:0] S_M    = 5'd18;
    localparam logic [RF_AW-1:0] S_KZ   = 5'd19;
    localparam logic [RF_AW-1:0] S_OL   = 5'd20;
    localparam logic [RF_AW-1:0] S_UO   = 5'd21;
    localparam logic [RF_AW-1:0] S_UT   = 5'd22;
    localparam logic [RF_AW-1:0] S_HT   = 5'd23;
    localparam logic [RF_AW-1:0] S_LOT  = 5'd24;
    localparam logic [RF_AW-1:0] S_DO   = 5'd25;
    localparam logic [RF_AW-1:0] S_DT   = 5'd26;
    localparam logic [RF_AW-1:0] S_T1   = 5'd27;
    localparam logic [RF_AW-1:0] S_T2   = 5'd28;
    localparam logic [RF_AW-1:0] S_BB   = 5'd29;
    localparam logic [RF_AW-1:0] S_T3   = 5'd30;
    localparam logic [RF_AW-1:0] S_T4   = 5'd31;

    localparam logic [3:0]      LOAD_LAST = 4'd14;
    localparam logic [PC_W-1:0] PC_CONS   = 7'd67;

    function automatic t_uop mk(input t_op op, input logic [RF_AW-1:0] d,
                                input logic [RF_AW-1:0] a, input logic [RF_AW-1:0] b);
        t_uop u;
        u.op = op;
        u.d  = d;
        u.a  = a;
        u.b  = b;
        return u;
    endfunction

    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            // shared terms
            7'd0:  u = mk(OP_MUL,  S_T1,   S_RHO,  S_AO);
            7'd1:  u = mk(OP_SUB,  S_ZO,   S_T1,   S_YO);
            7'd2:  u = mk(OP_SUB,  S_ZO,   S_ZO,   S_C);
            7'd3:  u = mk(OP_MUL,  S_T1,   S_RHO,  S_AT);
            7'd4:  u = mk(OP_SUB,  S_ZT,   S_T1,   S_YT);
            7'd5:  u = mk(OP_MUL,  S_T1,   S_KO,   S_KO);
            7'd6:  u = mk(OP_MUL,  S_T2,   S_KT,   S_KT);
            7'd7:  u = mk(OP_ADD,  S_N,    S_T1,   S_T2);
            7'd8:  u = mk(OP_SUB,  S_M,    S_N,    S_T1);
            7'd9:  u = mk(OP_MUL,  S_T1,   S_KO,   S_ZO);
            7'd10: u = mk(OP_MUL,  S_T2,   S_KT,   S_ZT);
            7'd11: u = mk(OP_ADD,  S_KZ,   S_T1,   S_T2);
            7'd12: u = mk(OP_SUB,  S_OL,   S_O,    S_L);
            7'd13: u = mk(OP_ADD,  S_HT,   S_HUN,  S_TOL);
            7'd14: u = mk(OP_SUB,  S_LOT,  S_L,    S_O);
            7'd15: u = mk(OP_SUB,  S_LOT,  S_LOT,  S_TOL);
            7'd16: u = mk(OP_DIV,  S_UO,   S_ZO,   S_RHO);
            7'd17: u = mk(OP_DIV,  S_UT,   S_ZT,   S_RHO);
            // unconstrained
            7'd18: u = mk(OP_CLR,  S_ZERO, S_ZERO, S_ZERO);
            7'd19: u = mk(OP_CHKZ, S_ZERO, S_RHO,  S_RHO);
            7'd20: u = mk(OP_ADD,  S_DO,   S_UO,   S_ZERO);
            7'd21: u = mk(OP_ADD,  S_DT,   S_UT,   S_ZERO);
            7'd22: u = mk(OP_CALL, S_ZERO, S_ZERO, S_ZERO);
            // linear bound face
            7'd23: u = mk(OP_CLR,  S_ZERO, S_ZERO, S_ZERO);
            7'd24: u = mk(OP_DIV,  S_T1,   S_KZ,   S_RHO);
            7'd25: u = mk(OP_ADD,  S_T1,   S_OL,   S_T1);
            7'd26: u = mk(OP_DIV,  S_T1,   S_T1,   S_N);
            7'd27: u = mk(OP_MUL,  S_T2,   S_KO,   S_T1);
            7'd28: u = mk(OP_SUB,  S_DO,   S_UO,   S_T2);
            7'd29: u = mk(OP_MUL,  S_T2,   S_KT,   S_T1);
            7'd30: u = mk(OP_SUB,  S_DT,   S_UT,   S_T2);
            7'd31: u = mk(OP_CALL, S_ZERO, S_ZERO, S_ZERO);
            // zero face
            7'd32: u = mk(OP_CLR,  S_ZERO, S_ZERO, S_ZERO);
            7'd33: u = mk(OP_CHKZ, S_ZERO, S_RHO,  S_RHO);
            7'd34: u = mk(OP_ADD,  S_DO,   S_ZERO, S_ZERO);
            7'd35: u = mk(OP_ADD,  S_DT,   S_UT,   S_ZERO);
            7'd36: u = mk(OP_CALL, S_ZERO, S_ZERO, S_ZERO);
            // full face
            7'd37: u = mk(OP_CLR,  S_ZERO, S_ZERO, S_ZERO);
            7'd38: u = mk(OP_CHKZ, S_ZERO, S_RHO,  S_RHO);
            7'd39: u = mk(OP_ADD,  S_DO,   S_HUN,  S_ZERO);
            7'd40: u = mk(OP_ADD,  S_DT,   S_UT,   S_ZERO);
            7'd41: u = mk(OP_CALL, S_ZERO, S_ZERO, S_ZERO);
            // linear and zero
            7'd42: u = mk(OP_CLR,  S_ZERO, S_ZERO, S_ZERO);
            7'd43: u = mk(OP_DIV,  S_T1,   S_OL,   S_M);
            7'd44: u = mk(OP_MUL,  S_T2,   S_KO,   S_ZO);
            7'd45: u = mk(OP_SUB,  S_T2,   S_T2,   S_KZ);
            7'd46: u = mk(OP_DIV,  S_T2,   S_T2,   S_RHO);
            7'd47: u = mk(OP_DIV,  S_BB,   S_T2,   S_M);
            7'd48: u = mk(OP_MUL,  S_T2,   S_KT,   S_T1);
            7'd49: u = mk(OP_SUB,  S_DT,   S_UT,   S_T2);
            7'd50: u = mk(OP_MUL,  S_T2,   S_KT,   S_BB);
            7'd51: u = mk(OP_ADD,  S_DT,   S_DT,   S_T2);
            7'd52: u = mk(OP_ADD,  S_DO,   S_ZERO, S_ZERO);
            7'd53: u = mk(OP_CALL, S_ZERO, S_ZERO, S_ZERO);
            // linear and full
            7'd54: u = mk(OP_CLR,  S_ZERO, S_ZERO, S_ZERO);
            7'd55: u = mk(OP_CHKZ, S_ZERO, S_RHO,  S_RHO);
            7'd56: u = mk(OP_CHKZ, S_ZERO, S_M,    S_M);
            7'd57: u = mk(OP_MUL,  S_T1,   S_HUN,  S_KO);
            7'd58: u = mk(OP_ADD,  S_T1,   S_OL,   S_T1);
            7'd59: u = mk(OP_DIV,  S_T1,   S_T1,   S_M);
            7'd60: u = mk(OP_MUL,  S_T2,   S_KT,   S_T1);
            7'd61: u = mk(OP_SUB,  S_DT,   S_UT,   S_T2);
            7'd62: u = mk(OP_MUL,  S_T2,   S_KT,   S_BB);
            7'd63: u = mk(OP_ADD,  S_DT,   S_DT,   S_T2);
            7'd64: u = mk(OP_ADD,  S_DO,   S_HUN,  S_ZERO);
            7'd65: u = mk(OP_CALL, S_ZERO, S_ZERO, S_ZERO);
            7'd66: u = mk(OP_END,  S_ZERO, S_ZERO, S_ZERO);
            // candidate check and scoring
            7'd67: u = mk(OP_LATCH, S_ZERO, S_DO,  S_DT);
            7'd68: u = mk(OP_LT,   S_ZERO, S_DO,   S_NTOL);
            7'd69: u = mk(OP_LT,   S_ZERO, S_HT,   S_DO);
            7'd70: u = mk(OP_MUL,  S_T3,   S_DO,   S_KO);
            7'd71: u = mk(OP_MUL,  S_T4,   S_DT,   S_KT);
            7'd72: u = mk(OP_ADD,  S_T3,   S_T3,   S_T4);
            7'd73: u = mk(OP_LT,   S_ZERO, S_T3,   S_LOT);
            7'd74: u = mk(OP_MUL,  S_T1,   S_C,    S_DO);
            7'd75: u = mk(OP_SUB,  S_DO,   S_DO,   S_AO);
            7'd76: u = mk(OP_SUB,  S_DT,   S_DT,   S_AT);
            7'd77: u = mk(OP_MUL,  S_T2,   S_YO,   S_DO);
            7'd78: u = mk(OP_MUL,  S_T3,   S_YT,   S_DT);
            7'd79: u = mk(OP_ADD,  S_T2,   S_T2,   S_T3);
            7'd80: u = mk(OP_ADD,  S_T1,   S_T1,   S_T2);
            7'd81: u = mk(OP_MUL,  S_T2,   S_DO,   S_DO);
            7'd82: u = mk(OP_MUL,  S_T3,   S_DT,   S_DT);
            7'd83: u = mk(OP_ADD,  S_T2,   S_T2,   S_T3);
            7'd84: u = mk(OP_MUL,  S_T2,   S_RH,   S_T2);
            7'd85: u = mk(OP_ADD,  S_T1,   S_T1,   S_T2);
            7'd86: u = mk(OP_SEL,  S_ZERO, S_T1,   S_ZERO);
            7'd87: u = mk(OP_RET,  S_ZERO, S_ZERO, S_ZERO);
            default: u = mk(OP_END, S_ZERO, S_ZERO, S_ZERO);
        endcase
        return u;
    endfunction

endpackage

/* hdl/alps_arith.sv */
// shared saturating arithmetic unit: add, subtract, compare, fixed point multiply and
// serial restoring divide; depends on alps_pkg
module alps_arith #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  alps_pkg::t_arith_req i_req,
    output alps_pkg::t_arith_rsp o_rsp
);
    import alps_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW);
    localparam logic signed [63:0] QMAX64 = 64'sd2147483647;
    localparam logic signed [63:0] QMIN64 = -64'sd2147483648;
    localparam logic signed [63:0] RND    = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    t_arith_state      r_state, n_state;
    logic              r_done, n_done;
    logic              r_flag, n_flag;
    logic [31:0]       r_result, n_result;
    logic signed [63:0] r_prod, n_prod;
    logic [NW-1:0]     r_num, n_num;
    logic [31:0]       r_den, n_den;
    logic [31:0]       r_rem, n_rem;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_neg, n_neg;

    logic signed [32:0] sum_add, sum_sub;
    logic [31:0]       a_mag, b_mag;
    logic signed [63:0] p_adj, p_q;
    logic [32:0]       shifted;
    logic              q_fit;
    logic [NW:0]       q_ext;

    always_comb begin
        sum_add = {i_req.a[31], i_req.a} + {i_req.b[31], i_req.b};
        sum_sub = {i_req.a[31], i_req.a} - {i_req.b[31], i_req.b};
        a_mag   = i_req.a[31] ? (32'd0 - i_req.a) : i_req.a;
        b_mag   = i_req.b[31] ? (32'd0 - i_req.b) : i_req.b;
        p_adj   = r_prod + (r_prod[63] ? RND : 64'sd0);
        p_q     = p_adj >>> FRAC_BITS;
        shifted = {r_rem, r_num[NW-1]};
        q_fit   = shifted >= {1'b0, r_den};
        q_ext   = {1'b0, r_num};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            AR_IDLE: begin
                if (i_req.start && i_req.op == OP_MUL) begin
                    n_state = AR_MUL;
                end else if (i_req.start && i_req.op == OP_DIV && i_req.b != 32'd0) begin
                    n_state = AR_DIV;
                end
            end
            AR_MUL: n_state = AR_IDLE;
            AR_DIV: begin
                if (r_cnt == CW'(NW - 1)) begin
                    n_state = AR_FIN;
                end
            end
            AR_FIN: n_state = AR_IDLE;
            default: n_state = AR_IDLE;
        endcase
    end

    always_comb begin
        n_done   = 1'b0;
        n_flag   = 1'b0;
        n_result = r_result;
        n_prod   = r_prod;
        n_num    = r_num;
        n_den    = r_den;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        case (r_state)
            AR_IDLE: begin
                if (i_req.start) begin
                    case (i_req.op)
                        OP_ADD: begin
                            n_done   = 1'b1;
                            n_result = (sum_add[32] != sum_add[31])
                                     ? (sum_add[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                     : sum_add[31:0];
                        end
                        OP_SUB: begin
                            n_done   = 1'b1;
                            n_result = (sum_sub[32] != sum_sub[31])
                                     ? (sum_sub[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                     : sum_sub[31:0];
                        end
                        OP_LT: begin
                            n_done = 1'b1;
                            n_flag = $signed(i_req.a) < $signed(i_req.b);
                        end
                        OP_CHKZ: begin
                            n_done = 1'b1;
                            n_flag = i_req.b == 32'd0;
                        end
                        OP_MUL: begin
                            n_prod = $signed(i_req.a) * $signed(i_req.b);
                        end
                        OP_DIV: begin
                            if (i_req.b == 32'd0) begin
                                n_done   = 1'b1;
                                n_flag   = 1'b1;
                                n_result = 32'd0;
                            end else begin
                                n_num = {a_mag, {FRAC_BITS{1'b0}}};
                                n_den = b_mag;
                                n_rem = 32'd0;
                                n_cnt = '0;
                                n_neg = i_req.a[31] ^ i_req.b[31];
                            end
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            AR_MUL: begin
                n_done = 1'b1;
                if (p_q > QMAX64) begin
                    n_result = 32'h7FFF_FFFF;
                end else if (p_q < QMIN64) begin
                    n_result = 32'h8000_0000;
                end else begin
                    n_result = p_q[31:0];
                end
            end
            AR_DIV: begin
                n_rem = q_fit ? 32'(shifted - {1'b0, r_den}) : shifted[31:0];
                n_num = {r_num[NW-2:0], q_fit};
                n_cnt = r_cnt + CW'(1);
            end
            AR_FIN: begin
                n_done = 1'b1;
                if (r_neg) begin
                    n_result = (q_ext > (NW+1)'(33'h0_8000_0000)) ? 32'h8000_0000
                             : 32'd0 - r_num[31:0];
                end else begin
                    n_result = (q_ext > (NW+1)'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF
                             : r_num[31:0];
                end
            end
            default: n_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AR_IDLE;
            r_done  <= 1'b0;
            r_flag  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_flag  <= n_flag;
        end
        r_result <= n_result;
        r_prod   <= n_prod;
        r_num    <= n_num;
        r_den    <= n_den;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_neg    <= n_neg;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.flag   = r_flag;
    assign o_rsp.result = r_result;

endmodule

/* hdl/admm_local_primal_solve.sv */
// top level of the admm local primal solve block: sequencer, register file, result path
// depends on alps_pkg and alps_arith
//
// usage: one input item carries the consensus average and dual vector of two elements.
// the block forms six candidate duty vectors, checks each against the bounds and the
// illuminance constraint and returns the cheapest feasible one as one result item.
// channels: input and output use valid / stall; an item moves when valid is high and
// stall is low. configuration uses valid / ready (ready always high), index selects
// the register; write only while no item is in flight.
// sequence: 15 register file slots are loaded, then 193 micro-program steps run on one
// shared unit (the scoring routine runs once per candidate): eight divisions, 62
// multiplies, 92 add / compare steps and the rest control steps; the divide is serial.
// if no candidate is feasible, the result carries the kept duty vector.
// one item is worked on at a time; input stall is high meanwhile.
// the finished result sits in an output register, so a new item is accepted while it
// waits; if the receiver stalls, the next result waits until the register frees.
// reset restores the configuration defaults and clears the kept duty vector.
module admm_local_primal_solve #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_avg_first,
    input  logic [31:0] i_avg_second,
    input  logic [31:0] i_dual_first,
    input  logic [31:0] i_dual_second,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_duty_first,
    output logic [31:0] o_duty_second,
    output logic [31:0] o_best_cost,
    output logic        o_found,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import alps_pkg::*;

    localparam longint TOL_L  = ((64'sd1 <<< FRAC_BITS) + 64'sd500) / 64'sd1000;
    localparam longint HUN_L  = 64'sd100 <<< FRAC_BITS;
    localparam longint BIG_L  = 64'sd10000 <<< FRAC_BITS;
    localparam logic [31:0] TOL_Q  = 32'(TOL_L);
    localparam logic [31:0] NTOL_Q = 32'(-TOL_L);
    localparam logic [31:0] HUN_Q  = (HUN_L > 64'sd2147483647) ? 32'h7FFF_FFFF : 32'(HUN_L);
    localparam logic [31:0] BEST_INIT =
        (BIG_L > 64'sd2147483647) ? 32'h7FFF_FFFF : 32'(BIG_L);

    function automatic logic [31:0] int_to_q(input logic [15:0] v);
        logic [47:0] w;
        w = 48'(v) << FRAC_BITS;
        return (w > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : w[31:0];
    endfunction

    t_seq_state      r_state, n_state;
    logic [PC_W-1:0] r_pc, r_ret;
    logic [3:0]      r_ld_cnt;
    logic            r_bad, r_found;
    logic [31:0]     r_best, r_cand_o, r_cand_t, r_bestd_o, r_bestd_t;
    logic [31:0]     r_kept_first, r_kept_second;
    logic [31:0]     r_avg0, r_avg1, r_dual0, r_dual1;
    logic [30:0]     r_rho, r_gain0, r_gain1;
    logic [15:0]     r_cost, r_ext, r_lower;
    logic            r_own;
    logic            r_out_valid, r_out_found;
    logic [31:0]     r_out_d0, r_out_d1, r_out_cost;

    logic [31:0]     r_rf [2**RF_AW];
    logic [31:0]     r_rda, r_rdb;

    t_uop            uop;
    t_arith_req      req;
    t_arith_rsp      rsp;
    logic            in_take, out_free, is_arith, writes_rf, rf_we;
    logic [RF_AW-1:0] rf_wa;
    logic [31:0]     rf_wd, ld_val, fin_d0, fin_d1;

    alps_arith #(
        .FRAC_BITS(FRAC_BITS)
    ) u_arith (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp)
    );

    assign uop         = uop_rom(r_pc);
    assign o_in_stall  = r_state != SQ_IDLE;
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        case (uop.op)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                is_arith  = 1'b1;
                writes_rf = 1'b1;
            end
            OP_LT, OP_CHKZ: begin
                is_arith  = 1'b1;
                writes_rf = 1'b0;
            end
            default: begin
                is_arith  = 1'b0;
                writes_rf = 1'b0;
            end
        endcase
    end

    // initial register file contents, vectors in own / other order
    always_comb begin
        case ({1'b0, r_ld_cnt})
            S_RHO:  ld_val = {1'b0, r_rho};
            S_RH:   ld_val = {2'b00, r_rho[30:1]};
            S_C:    ld_val = int_to_q(r_cost);
            S_O:    ld_val = int_to_q(r_ext);
            S_L:    ld_val = int_to_q(r_lower);
            S_KO:   ld_val = {1'b0, r_own ? r_gain1 : r_gain0};
            S_KT:   ld_val = {1'b0, r_own ? r_gain0 : r_gain1};
            S_AO:   ld_val = r_own ? r_avg1 : r_avg0;
            S_AT:   ld_val = r_own ? r_avg0 : r_avg1;
            S_YO:   ld_val = r_own ? r_dual1 : r_dual0;
            S_YT:   ld_val = r_own ? r_dual0 : r_dual1;
            S_HUN:  ld_val = HUN_Q;
            S_NTOL: ld_val = NTOL_Q;
            S_TOL:  ld_val = TOL_Q;
            default: ld_val = 32'd0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            SQ_IDLE:  if (in_take) n_state = SQ_LOAD;
            SQ_LOAD:  if (r_ld_cnt == LOAD_LAST) n_state = SQ_FETCH;
            SQ_FETCH: n_state = SQ_ISSUE;
            SQ_ISSUE: begin
                if (is_arith) begin
                    n_state = SQ_WAIT;
                end else if (uop.op == OP_END) begin
                    n_state = SQ_DONE;
                end else begin
                    n_state = SQ_FETCH;
                end
            end
            SQ_WAIT:  if (rsp.done) n_state = SQ_FETCH;
            SQ_DONE:  if (out_free) n_state = SQ_IDLE;
            default:  n_state = SQ_IDLE;
        endcase
    end

    always_comb begin
        req.start = (r_state == SQ_ISSUE) && is_arith;
        req.op    = uop.op;
        req.a     = r_rda;
        req.b     = r_rdb;
        rf_we     = (r_state == SQ_LOAD) || ((r_state == SQ_WAIT) && rsp.done && writes_rf);
        rf_wa     = (r_state == SQ_LOAD) ? {1'b0, r_ld_cnt} : uop.d;
        rf_wd     = (r_state == SQ_LOAD) ? ld_val : rsp.result;
        fin_d0    = r_found ? (r_own ? r_bestd_t : r_bestd_o) : r_kept_first;
        fin_d1    = r_found ? (r_own ? r_bestd_o : r_bestd_t) : r_kept_second;
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_wa] <= rf_wd;
        end
        r_rda <= r_rf[uop.a];
        r_rdb <= r_rf[uop.b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= SQ_IDLE;
            r_pc          <= '0;
            r_ret         <= '0;
            r_ld_cnt      <= '0;
            r_bad         <= 1'b0;
            r_found       <= 1'b0;
            r_best        <= BEST_INIT;
            r_kept_first  <= 32'd0;
            r_kept_second <= 32'd0;
            r_out_valid   <= 1'b0;
            r_rho         <= 31'd65536;
            r_cost        <= 16'd1;
            r_ext         <= 16'd0;
            r_lower       <= 16'd0;
            r_own         <= 1'b0;
            r_gain0       <= 31'd131072;
            r_gain1       <= 31'd65536;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RHO:   r_rho   <= i_cfg_data[30:0];
                    CFG_COST:  r_cost  <= i_cfg_data[15:0];
                    CFG_EXT:   r_ext   <= i_cfg_data[15:0];
                    CFG_LOWER: r_lower <= i_cfg_data[15:0];
                    CFG_OWN:   r_own   <= i_cfg_data[0];
                    CFG_GAIN0: r_gain0 <= i_cfg_data[30:0];
                    CFG_GAIN1: r_gain1 <= i_cfg_data[30:0];
                    default:   r_own   <= r_own;
                endcase
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                SQ_IDLE: begin
                    if (in_take) begin
                        r_pc     <= '0;
                        r_ld_cnt <= '0;
                        r_bad    <= 1'b0;
                        r_found  <= 1'b0;
                        r_best   <= BEST_INIT;
                    end
                end
                SQ_LOAD: r_ld_cnt <= r_ld_cnt + 4'd1;
                SQ_ISSUE: begin
                    case (uop.op)
                        OP_CLR: begin
                            r_bad <= 1'b0;
                            r_pc  <= r_pc + PC_W'(1);
                        end
                        OP_LATCH: r_pc <= r_pc + PC_W'(1);
                        OP_SEL: begin
                            if (!r_bad && ($signed(r_rda) < $signed(r_best))) begin
                                r_best    <= r_rda;
                                r_bestd_o <= r_cand_o;
                                r_bestd_t <= r_cand_t;
                                r_found   <= 1'b1;
                            end
                            r_pc <= r_pc + PC_W'(1);
                        end
                        OP_CALL: begin
                            r_ret <= r_pc + PC_W'(1);
                            r_pc  <= PC_CONS;
                        end
                        OP_RET: r_pc <= r_ret;
                        default: r_pc <= r_pc;
                    endcase
                end
                SQ_WAIT: begin
                    if (rsp.done) begin
                        r_bad <= r_bad | rsp.flag;
                        r_pc  <= r_pc + PC_W'(1);
                    end
                end
                SQ_DONE: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_kept_first  <= fin_d0;
                        r_kept_second <= fin_d1;
                    end
                end
                default: r_pc <= r_pc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_avg0  <= i_avg_first;
            r_avg1  <= i_avg_second;
            r_dual0 <= i_dual_first;
            r_dual1 <= i_dual_second;
        end
        if (r_state == SQ_ISSUE && uop.op == OP_LATCH) begin
            r_cand_o <= r_rda;
            r_cand_t <= r_rdb;
        end
        if (r_state == SQ_DONE && out_free) begin
            r_out_d0    <= fin_d0;
            r_out_d1    <= fin_d1;
            r_out_cost  <= r_best;
            r_out_found <= r_found;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_duty_first  = r_out_d0;
    assign o_duty_second = r_out_d1;
    assign o_best_cost   = r_out_cost;
    assign o_found       = r_out_found;

endmodule

/* sim/admm_primal_checker.sv */
`timescale 1ns / 1ps
// checker for the admm local primal solve block: watches the config, input and output channels,
// predicts each result from its own copy of the configuration and kept vector, and compares
// depends on alps_pkg for the config register indexes
module admm_primal_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_avg_first,
    input  logic [31:0] i_avg_second,
    input  logic [31:0] i_dual_first,
    input  logic [31:0] i_dual_second,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_duty_first,
    input  logic [31:0] i_duty_second,
    input  logic [31:0] i_best_cost,
    input  logic        i_found,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    import alps_pkg::*;

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam longint QONE = 64'sd65536;

    typedef struct {
        logic [31:0] duty_first;
        logic [31:0] duty_second;
        logic [31:0] cost;
        logic        found;
    } t_solution;

    t_solution solution_q[$];

    longint rho, cost_w, ext_lux, lower_lux, gain0, gain1;
    bit     own;
    longint kept0, kept1;

    longint g_avg[2], g_dual[2], g_gain[2], g_c, g_rho, g_lower, g_ext;
    longint best_cost, best0, best1;
    bit     div_fault, any_found;

    function longint sat(input longint v);
        return v > QMAX ? QMAX : (v < QMIN ? QMIN : v);
    endfunction

    function longint qmul(input longint a, input longint b);
        return sat((a * b) / QONE);
    endfunction

    function longint qdiv(input longint a, input longint b);
        if (b == 0) begin
            div_fault = 1;
            return 0;
        end
        return sat((a * QONE) / b);
    endfunction

    function longint sx(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function void score(input longint d0, input longint d1);
        longint tol, d_own, e0, e1, c;
        tol = (QONE + 500) / 1000;
        d_own = own ? d1 : d0;
        if (div_fault) return;
        if (d_own < -tol) return;
        if (d_own > sat(sat(100 * QONE) + tol)) return;
        if (sat(qmul(d0, g_gain[0]) + qmul(d1, g_gain[1])) < sat(sat(g_lower - g_ext) - tol))
            return;
        e0 = sat(d0 - g_avg[0]);
        e1 = sat(d1 - g_avg[1]);
        c = sat(sat(qmul(g_c, d_own) + sat(qmul(g_dual[0], e0) + qmul(g_dual[1], e1)))
                + qmul(g_rho / 2, sat(qmul(e0, e0) + qmul(e1, e1))));
        if (c < best_cost) begin
            best_cost = c;
            best0 = d0;
            best1 = d1;
            any_found = 1;
        end
    endfunction

    function t_solution predict(input logic [31:0] a0, input logic [31:0] a1,
                                input logic [31:0] y0, input logic [31:0] y1);
        longint z[2], d[2], n, m, kz, ol, t, s, a, b, hun;
        t_solution r;
        int i;
        hun = sat(100 * QONE);
        g_avg[0] = sx(a0);
        g_avg[1] = sx(a1);
        g_dual[0] = sx(y0);
        g_dual[1] = sx(y1);
        g_gain[0] = gain0;
        g_gain[1] = gain1;
        g_rho = rho;
        g_c = sat(cost_w * QONE);
        g_ext = sat(ext_lux * QONE);
        g_lower = sat(lower_lux * QONE);
        best_cost = sat(10000 * QONE);
        any_found = 0;
        for (i = 0; i < 2; i++) z[i] = sat(qmul(g_rho, g_avg[i]) - g_dual[i]);
        z[own] = sat(z[own] - g_c);
        n = sat(qmul(g_gain[0], g_gain[0]) + qmul(g_gain[1], g_gain[1]));
        m = sat(n - qmul(g_gain[own], g_gain[own]));
        kz = sat(qmul(g_gain[0], z[0]) + qmul(g_gain[1], z[1]));
        ol = sat(g_ext - g_lower);

        // unconstrained
        div_fault = 0;
        for (i = 0; i < 2; i++) d[i] = qdiv(z[i], g_rho);
        score(d[0], d[1]);
        // linear bound face
        div_fault = 0;
        t = sat(ol + qdiv(kz, g_rho));
        s = qdiv(t, n);
        for (i = 0; i < 2; i++) d[i] = sat(qdiv(z[i], g_rho) - qmul(g_gain[i], s));
        score(d[0], d[1]);
        // zero face
        div_fault = 0;
        for (i = 0; i < 2; i++) d[i] = qdiv(z[i], g_rho);
        d[own] = 0;
        score(d[0], d[1]);
        // full face
        div_fault = 0;
        for (i = 0; i < 2; i++) d[i] = qdiv(z[i], g_rho);
        d[own] = hun;
        score(d[0], d[1]);
        // linear and zero
        div_fault = 0;
        a = qdiv(ol, m);
        b = qdiv(qdiv(sat(qmul(g_gain[own], z[own]) - kz), g_rho), m);
        for (i = 0; i < 2; i++)
            d[i] = sat(sat(qdiv(z[i], g_rho) - qmul(g_gain[i], a)) + qmul(g_gain[i], b));
        d[own] = 0;
        score(d[0], d[1]);
        // linear and full
        div_fault = 0;
        a = qdiv(sat(ol + qmul(hun, g_gain[own])), m);
        b = qdiv(qdiv(sat(qmul(g_gain[own], z[own]) - kz), g_rho), m);
        for (i = 0; i < 2; i++)
            d[i] = sat(sat(qdiv(z[i], g_rho) - qmul(g_gain[i], a)) + qmul(g_gain[i], b));
        d[own] = hun;
        score(d[0], d[1]);

        if (any_found) begin
            kept0 = best0;
            kept1 = best1;
        end
        r.duty_first = kept0[31:0];
        r.duty_second = kept1[31:0];
        r.cost = best_cost[31:0];
        r.found = any_found;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_solution want;
        if (!i_rst_n) begin
            rho <= 65536;
            cost_w <= 1;
            ext_lux <= 0;
            lower_lux <= 0;
            own <= 0;
            gain0 <= 131072;
            gain1 <= 65536;
            kept0 = 0;
            kept1 = 0;
            o_errors <= 0;
            solution_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RHO:   rho <= {33'd0, i_cfg_data[30:0]};
                    CFG_COST:  cost_w <= {48'd0, i_cfg_data[15:0]};
                    CFG_EXT:   ext_lux <= {48'd0, i_cfg_data[15:0]};
                    CFG_LOWER: lower_lux <= {48'd0, i_cfg_data[15:0]};
                    CFG_OWN:   own <= i_cfg_data[0];
                    CFG_GAIN0: gain0 <= {33'd0, i_cfg_data[30:0]};
                    CFG_GAIN1: gain1 <= {33'd0, i_cfg_data[30:0]};
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                solution_q.push_back(predict(i_avg_first, i_avg_second, i_dual_first,
                                             i_dual_second));
            if (i_out_valid && !i_out_stall) begin
                if (solution_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result item at %0t", $time);
                    o_errors <= o_errors + 1;
                end else begin
                    want = solution_q.pop_front();
                    if (want.duty_first !== i_duty_first || want.duty_second !== i_duty_second
                        || want.cost !== i_best_cost || want.found !== i_found) begin
                        if (o_errors < 10)
                            $display("mismatch at %0t: exp %h %h %h %b got %h %h %h %b", $time,
                                     want.duty_first, want.duty_second, want.cost, want.found,
                                     i_duty_first, i_duty_second, i_best_cost, i_found);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= solution_q.size();
    end
endmodule

/* sim/tb_admm_local_primal_solve.sv */
`timescale 1ns / 1ps
// testbench top for the admm local primal solve block: clock, reset, config phases, stimulus,
// randomized idling and the verdict; depends on alps_pkg, admm_primal_checker and the block
module tb_admm_local_primal_solve;
    import alps_pkg::*;

    localparam int WATCHDOG = 40000;
    localparam int HOLD_CYCLES = 4000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [31:0] avg_first = 0, avg_second = 0, dual_first = 0, dual_second = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [31:0] duty_first, duty_second, best_cost;
    logic        found;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_RHO;
    logic [31:0] cfg_data = 0;
    int          errors, pending;
    int          send_idle_pct = 0, recv_stall_pct = 0;
    bit          hold_req = 0;
    int          quiet = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    admm_local_primal_solve dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_avg_first(avg_first), .i_avg_second(avg_second),
        .i_dual_first(dual_first), .i_dual_second(dual_second),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_duty_first(duty_first), .o_duty_second(duty_second),
        .o_best_cost(best_cost), .o_found(found),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    admm_primal_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_avg_first(avg_first), .i_avg_second(avg_second),
        .i_dual_first(dual_first), .i_dual_second(dual_second),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_duty_first(duty_first), .i_duty_second(duty_second),
        .i_best_cost(best_cost), .i_found(found),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver, with a long hold-off on request
    always @(posedge i_clk) begin
        int held;
        if (hold_req) begin
            out_stall <= 1;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge i_clk);
            hold_req = 0;
        end
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [31:0] r, input logic [31:0] c,
                                 input logic [31:0] o, input logic [31:0] l,
                                 input logic [31:0] w, input logic [31:0] k0,
                                 input logic [31:0] k1);
        write_reg(CFG_RHO, r);
        write_reg(CFG_COST, c);
        write_reg(CFG_EXT, o);
        write_reg(CFG_LOWER, l);
        write_reg(CFG_OWN, w);
        write_reg(CFG_GAIN0, k0);
        write_reg(CFG_GAIN1, k1);
    endtask

    task automatic offer(input logic [31:0] a0, input logic [31:0] a1,
                         input logic [31:0] y0, input logic [31:0] y1);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_valid <= 1;
        avg_first <= a0;
        avg_second <= a1;
        dual_first <= y0;
        dual_second <= y1;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_avg();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 32'h0064_0000);
    endfunction

    function automatic logic [31:0] pick_dual();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 32'h0028_0000) - 32'h0014_0000;
    endfunction

    initial begin
        logic [31:0] corners[6];
        int ph, i;
        corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                    32'h0001_0000, 32'h0032_0000};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // default settings, field extremes and typical points
        for (i = 0; i < 6; i++) offer(corners[i], corners[5 - i], corners[(i + 2) % 6],
                                      corners[(i + 4) % 6]);
        for (i = 0; i < 6; i++) offer(corners[i], corners[i], 0, 0);
        offer(32'h0032_0000, 32'h0032_0000, 32'h0001_0000, 32'hffff_0000);
        drain();

        for (ph = 0; ph < 10; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            case (ph)
                0: load_settings(32'h7fff_ffff, 65535, 65535, 65535, 1,
                                 32'h7fff_ffff, 32'h7fff_ffff);
                1: load_settings(1, 0, 0, 0, 0, 0, 0);
                2: load_settings(32'h0001_0000, 1, 10, 300, 0, 32'h0002_0000, 0);
                3: load_settings(32'h0001_0000, 1, 10, 300, 1, 0, 32'h0003_0000);
                default: load_settings($urandom_range(32'h8000, 32'h0004_0000),
                                       $urandom_range(0, 10), $urandom_range(0, 200),
                                       $urandom_range(0, 400), $urandom_range(0, 1),
                                       $urandom_range(0, 32'h0003_0000),
                                       $urandom_range(0, 32'h0003_0000));
            endcase
            for (i = 0; i < 85; i++) begin
                if (ph == 5 && i == 3) hold_req = 1;
                offer(pick_avg(), pick_avg(), pick_dual(), pick_dual());
            end
            drain();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
